// File: hw/rtl/timed_entry_table_with_fade_assert.svh
// Assertion macros for the timed entry table checker.
// Needs clk and arst_n in the scope of each use.
`ifndef TIMED_ENTRY_TABLE_WITH_FADE_ASSERT_SVH
`define TIMED_ENTRY_TABLE_WITH_FADE_ASSERT_SVH
// same-cycle implication
`define TETF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timed entry table: same-cycle check failed");
// next-cycle implication
`define TETF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timed entry table: next-cycle check failed");
`endif

// File: hw/rtl/tetf_pkg.sv
// Shared types and codes for the timed entry table.
// No dependencies.
package tetf_pkg;
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SPAWN  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] KIND_LIVE   = 3'd0;
	localparam logic [2:0] KIND_SPAWN  = 3'd1;
	localparam logic [2:0] KIND_REMOVE = 3'd2;
	localparam logic [2:0] KIND_CLEAR  = 3'd3;
	localparam logic [2:0] KIND_EMPTY  = 3'd4;

	localparam logic [23:0] AGE_MAX = 24'hFFFFFF;

	typedef struct packed {
		logic [31:0] id;
		logic [23:0] age;
		logic [23:0] life;
		logic [15:0] fade;
	} entry_t;
endpackage

// File: hw/rtl/timed_entry_table_with_fade.sv
// Timed entry table with fade-out; top level. Uses tetf_pkg and tetf_ram.
// Spawn into a table that is not full, and clear, answer in the cycle after start;
// a full-table spawn and a remove walk the table, entry by entry.
// Tick walks the table entry by entry: read, age, up to nine divider steps, report.
// busy holds off start until the word is done; results are one-cycle strobes.
// arst_n empties the table, next id is 1.
module timed_entry_table_with_fade import tetf_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] delta_ms,
	input  logic [23:0] lifetime_ms,
	input  logic [15:0] fade_ms,
	input  logic [31:0] target_id,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [31:0] entry_id,
	output logic [7:0]  opacity,
	output logic        found,
	output logic        last
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TRD  = 4'd1;
	localparam logic [3:0] ST_TEV  = 4'd2;
	localparam logic [3:0] ST_TDIV = 4'd3;
	localparam logic [3:0] ST_TEMT = 4'd4;
	localparam logic [3:0] ST_TEND = 4'd5;
	localparam logic [3:0] ST_SRD  = 4'd6;
	localparam logic [3:0] ST_SEV  = 4'd7;
	localparam logic [3:0] ST_MRD  = 4'd8;
	localparam logic [3:0] ST_MEV  = 4'd9;
	localparam logic [3:0] ST_RRD  = 4'd10;
	localparam logic [3:0] ST_REV  = 4'd11;

	logic [3:0]    st_q;
	logic [CW-1:0] cnt_q, r_q, w_q;
	logic [IW-1:0] ev_q;
	logic [23:0]   ev_age_q;
	logic          have_q;
	logic [31:0]   nid_q;
	logic [15:0]   delta_q, fade_q;
	logic [23:0]   life_q;
	logic [31:0]   tgt_q;
	logic [31:0]   rem_q;
	logic [15:0]   dv_q;
	logic [3:0]    k_q;
	logic [7:0]    quo_q;
	logic [31:0]   cur_id_q, pend_id_q;
	logic [7:0]    cur_op_q, pend_op_q;
	logic          pend_v_q;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_wa, ram_ra;
	entry_t        ram_wd, rd;
	logic [EW-1:0] rd_raw;

	tetf_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH), .AW(IW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.re(ram_re), .raddr(ram_ra), .rdata(rd_raw)
	);
	assign rd = entry_t'(rd_raw);

	logic          accept, full;
	logic [24:0]   age_sum;
	logic [23:0]   age_new;
	logic          drop;
	logic [23:0]   diff;
	logic [31:0]   num;
	logic [15:0]   rd_f;
	logic [24:0]   rl_sum;
	logic [31:0]   dsh;
	logic          ge;
	logic [31:0]   nid_inc;

	assign accept  = start && !busy;
	assign busy    = (st_q != ST_IDLE);
	assign full    = (cnt_q == CW'(TABLE_DEPTH));
	assign age_sum = {1'b0, rd.age} + {9'd0, delta_q};
	assign age_new = age_sum[24] ? AGE_MAX : age_sum[23:0];
	assign drop    = (rd.life != 24'd0) && (age_new >= rd.life);
	assign diff    = rd.life - age_new;
	assign num     = {diff, 8'd0} - {8'd0, diff};
	assign rd_f    = (rd.fade == 16'd0) ? 16'd1 : rd.fade;
	assign rl_sum  = {1'b0, rd.age} + {9'd0, rd_f};
	assign dsh     = {16'd0, dv_q} << k_q;
	assign ge      = (rem_q >= dsh);
	assign nid_inc = (nid_q + 32'd1 == 32'd0) ? 32'd1 : nid_q + 32'd1;

	always_comb begin
		ram_we = 1'b0;
		ram_wa = w_q[IW-1:0];
		ram_wd = rd;
		ram_re = 1'b0;
		ram_ra = r_q[IW-1:0];
		case (st_q)
			ST_IDLE: begin
				ram_wa    = cnt_q[IW-1:0];
				ram_wd.id = nid_q;
				ram_wd.age = 24'd0;
				ram_wd.life = lifetime_ms;
				ram_wd.fade = fade_ms;
				ram_we = accept && (opcode == OP_SPAWN) && !full;
			end
			ST_TRD, ST_SRD, ST_RRD: ram_re = (r_q != cnt_q);
			ST_MRD: begin
				ram_re = (r_q != cnt_q);
				if (r_q == cnt_q) begin
					ram_we      = 1'b1;
					ram_wd.id   = nid_q;
					ram_wd.age  = 24'd0;
					ram_wd.life = life_q;
					ram_wd.fade = fade_q;
				end
			end
			ST_TEV: begin
				ram_wd.age = age_new;
				ram_we     = !drop;
			end
			ST_MEV: ram_we = 1'b1;
			ST_REV: begin
				ram_wa      = r_q[IW-1:0];
				ram_wd.life = rl_sum[24] ? AGE_MAX : rl_sum[23:0];
				ram_we      = (rd.id == tgt_q);
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= '0;
			nid_q    <= 32'd1;
			strobe   <= 1'b0;
			pend_v_q <= 1'b0;
			have_q   <= 1'b0;
			r_q      <= '0;
			w_q      <= '0;
		end else begin
			strobe <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						delta_q <= delta_ms;
						life_q  <= lifetime_ms;
						fade_q  <= fade_ms;
						tgt_q   <= target_id;
						r_q     <= '0;
						w_q     <= '0;
						have_q  <= 1'b0;
						pend_v_q <= 1'b0;
						kind     <= KIND_CLEAR;
						entry_id <= 32'd0;
						opacity  <= 8'd0;
						found    <= 1'b0;
						last     <= 1'b1;
						case (opcode)
							OP_TICK:   st_q <= ST_TRD;
							OP_SPAWN: begin
								if (full) begin
									st_q <= ST_SRD;
								end else begin
									cnt_q    <= cnt_q + CW'(1);
									nid_q    <= nid_inc;
									kind     <= KIND_SPAWN;
									entry_id <= nid_q;
									strobe   <= 1'b1;
								end
							end
							OP_REMOVE: st_q <= ST_RRD;
							default: begin
								cnt_q  <= '0;
								strobe <= 1'b1;
							end
						endcase
					end
				end
				ST_TRD: st_q <= (r_q == cnt_q) ? ST_TEND : ST_TEV;
				ST_TEV: begin
					r_q <= r_q + CW'(1);
					if (drop) begin
						st_q <= ST_TRD;
					end else begin
						w_q      <= w_q + CW'(1);
						cur_id_q <= rd.id;
						cur_op_q <= 8'd255;
						rem_q    <= num;
						dv_q     <= rd_f;
						k_q      <= 4'd8;
						quo_q    <= 8'd0;
						st_q     <= (rd.life == 24'd0) ? ST_TEMT : ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (k_q == 4'd8) begin
						if (ge) begin
							st_q <= ST_TEMT;
						end
						k_q <= 4'd7;
					end else begin
						if (ge) begin
							rem_q <= rem_q - dsh;
						end
						quo_q <= {quo_q[6:0], ge};
						k_q   <= k_q - 4'd1;
						if (k_q == 4'd0) begin
							cur_op_q <= {quo_q[6:0], ge};
							st_q     <= ST_TEMT;
						end
					end
				end
				ST_TEMT: begin
					if (pend_v_q) begin
						strobe   <= 1'b1;
						kind     <= KIND_LIVE;
						entry_id <= pend_id_q;
						opacity  <= pend_op_q;
						found    <= 1'b0;
						last     <= 1'b0;
					end
					pend_v_q  <= 1'b1;
					pend_id_q <= cur_id_q;
					pend_op_q <= cur_op_q;
					st_q      <= ST_TRD;
				end
				ST_TEND: begin
					strobe   <= 1'b1;
					kind     <= pend_v_q ? KIND_LIVE : KIND_EMPTY;
					entry_id <= pend_v_q ? pend_id_q : 32'd0;
					opacity  <= pend_v_q ? pend_op_q : 8'd0;
					found    <= 1'b0;
					last     <= 1'b1;
					cnt_q    <= w_q;
					st_q     <= ST_IDLE;
				end
				ST_SRD: begin
					if (r_q == cnt_q) begin
						if (have_q) begin
							r_q  <= CW'(ev_q) + CW'(1);
							w_q  <= CW'(ev_q);
							st_q <= ST_MRD;
						end else begin
							strobe   <= 1'b1;
							kind     <= KIND_SPAWN;
							entry_id <= 32'd0;
							st_q     <= ST_IDLE;
						end
					end else begin
						st_q <= ST_SEV;
					end
				end
				ST_SEV: begin
					if (rd.life != 24'd0 && (!have_q || rd.age > ev_age_q)) begin
						have_q   <= 1'b1;
						ev_q     <= r_q[IW-1:0];
						ev_age_q <= rd.age;
					end
					r_q  <= r_q + CW'(1);
					st_q <= ST_SRD;
				end
				ST_MRD: begin
					if (r_q == cnt_q) begin
						nid_q    <= nid_inc;
						strobe   <= 1'b1;
						kind     <= KIND_SPAWN;
						entry_id <= nid_q;
						st_q     <= ST_IDLE;
					end else begin
						st_q <= ST_MEV;
					end
				end
				ST_MEV: begin
					r_q  <= r_q + CW'(1);
					w_q  <= w_q + CW'(1);
					st_q <= ST_MRD;
				end
				ST_RRD: begin
					if (r_q == cnt_q) begin
						strobe   <= 1'b1;
						kind     <= KIND_REMOVE;
						entry_id <= tgt_q;
						found    <= 1'b0;
						st_q     <= ST_IDLE;
					end else begin
						st_q <= ST_REV;
					end
				end
				ST_REV: begin
					if (rd.id == tgt_q) begin
						strobe   <= 1'b1;
						kind     <= KIND_REMOVE;
						entry_id <= tgt_q;
						found    <= 1'b1;
						st_q     <= ST_IDLE;
					end else begin
						r_q  <= r_q + CW'(1);
						st_q <= ST_RRD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/tetf_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module tetf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/tetf_checker.sv
// Port-level checker for the timed entry table, bound to the top level.
// Uses tetf_pkg and timed_entry_table_with_fade_assert.svh.
`include "timed_entry_table_with_fade_assert.svh"
module tetf_checker import tetf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  opcode,
	input logic        strobe,
	input logic [2:0]  kind,
	input logic [7:0]  opacity,
	input logic        found,
	input logic        last
);
	`TETF_ASSERT_IMP(a_mid_live, strobe && !last, kind == KIND_LIVE)
	`TETF_ASSERT_IMP(a_found_remove, strobe && found, kind == KIND_REMOVE)
	`TETF_ASSERT_IMP(a_opac_zero, strobe && kind != KIND_LIVE, opacity == 8'd0)
	`TETF_ASSERT_NXT(a_clear_ack, start && !busy && opcode == OP_CLEAR,
		strobe && kind == KIND_CLEAR && !busy)
endmodule

bind timed_entry_table_with_fade tetf_checker u_tetf_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
	.strobe(strobe), .kind(kind), .opacity(opacity), .found(found), .last(last)
);

// File: tb/timed_entry_table_with_fade_checker.sv
`timescale 1ns / 1ps
// Checker for the timed entry table: watches the command and result channels,
// keeps its own copy of the table and compares every result word. Uses tetf_pkg.
module timed_entry_table_with_fade_checker import tetf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] delta_ms,
	input  logic [23:0] lifetime_ms,
	input  logic [15:0] fade_ms,
	input  logic [31:0] target_id,
	input  logic        strobe,
	input  logic [2:0]  kind,
	input  logic [31:0] entry_id,
	input  logic [7:0]  opacity,
	input  logic        found,
	input  logic        last,
	output int          fail_count,
	output int          words_pending
);
	localparam int DEPTH = 32;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] id;
		logic [7:0]  opac;
		logic        found;
		logic        last;
	} result_word_t;

	result_word_t awaited_words[$];
	entry_t       table_q[$];
	logic [31:0]  issue_id;

	assign words_pending = awaited_words.size();

	task automatic push_word(logic [2:0] k, logic [31:0] id, logic [7:0] op, logic fd,
			logic lst);
		result_word_t w;
		w.kind = k;
		w.id = id;
		w.opac = op;
		w.found = fd;
		w.last = lst;
		awaited_words.insert(awaited_words.size(), w);
	endtask

	task automatic predict_table(logic [1:0] op, logic [15:0] dl, logic [23:0] lf,
			logic [15:0] fd, logic [31:0] tg);
		int i;
		int ev;
		int n;
		logic [24:0] sum;
		logic [16:0] div;
		logic [39:0] q;
		logic [7:0] o;
		entry_t e;
		logic hit;
		case (op)
			OP_TICK: begin
				i = 0;
				n = 0;
				while (i < table_q.size()) begin
					e = table_q[i];
					sum = {1'b0, e.age} + dl;
					e.age = sum > AGE_MAX ? AGE_MAX : sum[23:0];
					table_q[i] = e;
					if (e.life != 0 && e.age >= e.life) begin
						table_q.delete(i);
					end else begin
						o = 8'hFF;
						if (e.life != 0) begin
							div = (e.fade == 0) ? 17'd1 : {1'b0, e.fade};
							q = (40'(e.life - e.age) * 40'd255) / 40'(div);
							o = q > 255 ? 8'hFF : q[7:0];
						end
						push_word(KIND_LIVE, e.id, o, 1'b0, 1'b0);
						n++;
						i++;
					end
				end
				if (n == 0)
					push_word(KIND_EMPTY, 32'd0, 8'd0, 1'b0, 1'b1);
				else
					awaited_words[$].last = 1'b1;
			end
			OP_SPAWN: begin
				ev = -1;
				if (table_q.size() >= DEPTH) begin
					for (i = 0; i < table_q.size(); i++)
						if (table_q[i].life != 0 && (ev < 0 || table_q[i].age > table_q[ev].age))
							ev = i;
					if (ev >= 0)
						table_q.delete(ev);
				end
				if (table_q.size() >= DEPTH) begin
					push_word(KIND_SPAWN, 32'd0, 8'd0, 1'b0, 1'b1);
				end else begin
					e.id = issue_id;
					e.age = '0;
					e.life = lf;
					e.fade = fd;
					table_q.insert(table_q.size(), e);
					push_word(KIND_SPAWN, issue_id, 8'd0, 1'b0, 1'b1);
					issue_id = (issue_id == 32'hFFFFFFFF) ? 32'd1 : issue_id + 1;
				end
			end
			OP_REMOVE: begin
				hit = 1'b0;
				for (i = 0; i < table_q.size() && !hit; i++)
					if (table_q[i].id == tg) begin
						e = table_q[i];
						sum = {1'b0, e.age} + ((e.fade == 0) ? 16'd1 : e.fade);
						e.life = sum > AGE_MAX ? AGE_MAX : sum[23:0];
						table_q[i] = e;
						hit = 1'b1;
					end
				push_word(KIND_REMOVE, tg, 8'd0, hit, 1'b1);
			end
			default: begin
				table_q.delete();
				push_word(KIND_CLEAR, 32'd0, 8'd0, 1'b0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			table_q.delete();
			awaited_words.delete();
			issue_id = 32'd1;
			fail_count = 0;
		end else begin
			if (strobe) begin
				if (awaited_words.size() == 0) begin
					$display("%0t: unexpected word kind=%0d id=%0h opac=%0d found=%0b last=%0b",
						$time, kind, entry_id, opacity, found, last);
					fail_count++;
				end else begin
					want = awaited_words.pop_front();
					if (want != {kind, entry_id, opacity, found, last}) begin
						$display("%0t: mismatch expected kind=%0d id=%0h opac=%0d found=%0b last=%0b",
							$time, want.kind, want.id, want.opac, want.found, want.last);
						$display("%0t:          actual   kind=%0d id=%0h opac=%0d found=%0b last=%0b",
							$time, kind, entry_id, opacity, found, last);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predict_table(opcode, delta_ms, lifetime_ms, fade_ms, target_id);
		end
	end
endmodule

// File: tb/tb_timed_entry_table_with_fade.sv
`timescale 1ns / 1ps
// Top of the timed entry table testbench: clock, reset, directed and random
// commands, watchdog and verdict. Needs the block, tetf_pkg and the checker.
module tb_timed_entry_table_with_fade;
	import tetf_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = OP_CLEAR;
	logic [15:0] delta_ms = '0;
	logic [23:0] lifetime_ms = '0;
	logic [15:0] fade_ms = '0;
	logic [31:0] target_id = '0;
	logic        strobe;
	logic [2:0]  kind;
	logic [31:0] entry_id;
	logic [7:0]  opacity;
	logic        found;
	logic        last;
	int          fail_count;
	int          words_pending;
	int          idle_pct = 0;
	int          spawns_sent = 0;
	int          quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	timed_entry_table_with_fade uut (.*);
	timed_entry_table_with_fade_checker chk (.*);

	always @(posedge clk) begin
		if (arst_n && !(start && !busy) && !strobe)
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic issue(logic [1:0] op, logic [15:0] dl, logic [23:0] lf, logic [15:0] fd,
			logic [31:0] tg);
		logic b;
		start <= 1'b1;
		opcode <= op;
		delta_ms <= dl;
		lifetime_ms <= lf;
		fade_ms <= fd;
		target_id <= tg;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
		if (op == OP_SPAWN)
			spawns_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic random_word();
		int r;
		logic [23:0] lf;
		logic [15:0] fd;
		logic [15:0] dl;
		logic [31:0] tg;
		int lo;
		r = $urandom_range(99);
		lf = ($urandom_range(99) < 15) ? 24'd0 :
			($urandom_range(99) < 8) ? 24'($urandom) : 24'($urandom_range(1, 2000));
		fd = ($urandom_range(99) < 8) ? 16'($urandom) : 16'($urandom_range(0, 1500));
		dl = ($urandom_range(99) < 6) ? 16'($urandom) : 16'($urandom_range(0, 300));
		lo = (spawns_sent > 40) ? spawns_sent - 40 : 1;
		tg = ($urandom_range(99) < 10) ? $urandom : 32'($urandom_range(lo, spawns_sent + 1));
		if (r < 40)
			issue(OP_SPAWN, 16'($urandom), lf, fd, 32'($urandom));
		else if (r < 72)
			issue(OP_TICK, dl, 24'($urandom), 16'($urandom), 32'($urandom));
		else if (r < 94)
			issue(OP_REMOVE, 16'($urandom), 24'($urandom), 16'($urandom), tg);
		else
			issue(OP_CLEAR, 16'($urandom), 24'($urandom), 16'($urandom), 32'($urandom));
	endtask

	initial begin
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		idle_pct = 10;

		issue(OP_TICK, 16'd0, 24'd0, 16'd0, 32'd0);
		issue(OP_REMOVE, 16'd0, 24'd0, 16'd0, 32'd0);
		issue(OP_SPAWN, 16'd0, 24'hFFFFFF, 16'hFFFF, 32'd0);
		issue(OP_SPAWN, 16'd0, 24'd0, 16'd0, 32'd0);
		issue(OP_SPAWN, 16'd0, 24'd100, 16'd0, 32'd0);
		issue(OP_SPAWN, 16'd0, 24'd1000, 16'd10, 32'd0);
		issue(OP_TICK, 16'd50, 24'd0, 16'd0, 32'd0);
		issue(OP_REMOVE, 16'd0, 24'd0, 16'd0, 32'd2);
		issue(OP_REMOVE, 16'd0, 24'd0, 16'd0, 32'hFFFFFFFF);
		issue(OP_TICK, 16'd0, 24'd0, 16'd0, 32'd0);
		issue(OP_TICK, 16'd60, 24'd0, 16'd0, 32'd0);
		issue(OP_TICK, 16'hFFFF, 24'd0, 16'd0, 32'd0);
		issue(OP_CLEAR, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
		issue(OP_TICK, 16'hFFFF, 24'd0, 16'd0, 32'd0);

		// saturate the age of a persistent and a long-lived entry
		issue(OP_SPAWN, 16'd0, 24'd0, 16'd5, 32'd0);
		issue(OP_SPAWN, 16'd0, 24'hFFFFFF, 16'hFFFF, 32'd0);
		for (k = 0; k < 260; k++)
			issue(OP_TICK, 16'hFFFF, 24'd0, 16'd0, 32'd0);
		issue(OP_REMOVE, 16'd0, 24'd0, 16'd0, 32'(spawns_sent - 1));
		issue(OP_TICK, 16'd1, 24'd0, 16'd0, 32'd0);
		issue(OP_CLEAR, 16'd0, 24'd0, 16'd0, 32'd0);

		for (k = 0; k < 90; k++) begin
			if (k == 30)
				idle_pct = 79;
			if (k == 60)
				idle_pct = 0;
			// fill with persistent entries and one finite, then force eviction and refusal
			if (k == 45) begin
				issue(OP_CLEAR, 16'd0, 24'd0, 16'd0, 32'd0);
				repeat (31) issue(OP_SPAWN, 16'd0, 24'd0, 16'($urandom_range(0, 500)),
					32'd0);
				issue(OP_SPAWN, 16'd0, 24'($urandom_range(1, 5000)),
					16'($urandom_range(0, 500)), 32'd0);
				repeat (2) issue(OP_SPAWN, 16'd0, 24'd0, 16'd0, 32'd0);
				issue(OP_TICK, 16'($urandom_range(0, 200)), 24'd0, 16'd0, 32'd0);
			end
			random_word();
		end
		start <= 1'b0;

		while (words_pending != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (fail_count == 0 && words_pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
